>>> src/nearest_neighbor_image_scaler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor image scaler
// Implication checks sampled on the rising clock edge, off while in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication
`define NNIS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nnis same-cycle check failed");

// Next-cycle implication
`define NNIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nnis next-cycle check failed");

`endif

>>> src/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared widths, beat types, register codes and helpers of the scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    // Size limits
    localparam int          MAX_SRC_DIM     = 64;
    localparam int          MAX_DST_DIM     = 256;
    localparam int unsigned DEF_SRC_PIXELS  = 4096;

    // Field widths
    localparam int PIX_W   = 32;
    localparam int SDIM_W  = 7;
    localparam int DDIM_W  = 9;
    localparam int COORD_W = 8;
    localparam int IDX_W   = 12;

    // Datapath widths
    localparam int PROD_W  = COORD_W + SDIM_W;
    localparam int Q_W     = $clog2(MAX_SRC_DIM);
    localparam int REM_W   = (PROD_W > DDIM_W + Q_W) ? PROD_W : DDIM_W + Q_W;
    localparam int AREA_W  = 2 * SDIM_W;
    localparam int CALC_W  = Q_W + SDIM_W + 1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic               opcode;
        logic [IDX_W-1:0]   src_index;
        logic [PIX_W-1:0]   pixel_in;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
    } nnis_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             out_of_range;
    } nnis_out_t;

    // Effective (saturated) image dimensions
    typedef struct packed {
        logic [SDIM_W-1:0] sw;
        logic [SDIM_W-1:0] sh;
        logic [DDIM_W-1:0] dw;
        logic [DDIM_W-1:0] dh;
    } nnis_dims_t;

    // Item state that rides along the divider stages
    typedef struct packed {
        logic             fetch;
        logic             load_ok;
        logic [IDX_W-1:0] src_index;
        logic [PIX_W-1:0] pixel;
        logic             oor;
    } nnis_side_t;

    // Store access request handed from the mapper to the pixel store
    typedef struct packed {
        logic              fetch;
        logic              wr_en;
        logic [CALC_W-1:0] index;
        logic [PIX_W-1:0]  wdata;
        logic              zero;
        logic              oor;
    } nnis_access_t;

    function automatic logic [SDIM_W-1:0] clamp_sdim(input logic [SDIM_W-1:0] v);
        logic [SDIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SDIM_W'(1);
        end else if (int'(v) > MAX_SRC_DIM) begin
            r = SDIM_W'(MAX_SRC_DIM);
        end
        return r;
    endfunction

    function automatic logic [DDIM_W-1:0] clamp_ddim(input logic [DDIM_W-1:0] v);
        logic [DDIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DDIM_W'(1);
        end else if (int'(v) > MAX_DST_DIM) begin
            r = DDIM_W'(MAX_DST_DIM);
        end
        return r;
    endfunction

endpackage

>>> src/nnis_divider.sv
// ----------------------------------------------------------------------------
// nnis_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module nnis_divider (
    input  logic                       aclk,
    input  logic                       advance,
    input  logic [nnis_pkg::PROD_W-1:0] dividend,
    input  logic [nnis_pkg::DDIM_W-1:0] divisor,
    output logic [nnis_pkg::Q_W-1:0]    quotient
);
    import nnis_pkg::*;

    logic [REM_W-1:0] rem_reg [Q_W-1];
    logic [Q_W-1:0]   quo_reg [Q_W];

    // One stage per quotient bit, most significant first
    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int B = Q_W - 1 - k;
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] sub;
        logic [Q_W-1:0]   quo_in;
        logic [Q_W-1:0]   quo_next;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = REM_W'(dividend);
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Compare against the shifted divisor
        assign sub = REM_W'(divisor) << B;
        assign ge  = (rem_in >= sub);

        always_comb begin
            quo_next    = quo_in;
            quo_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                quo_reg[k] <= quo_next;
            end
        end

        // Last stage keeps no remainder
        if (k < Q_W - 1) begin : g_rem
            logic [REM_W-1:0] rem_next;
            assign rem_next = ge ? (rem_in - sub) : rem_in;

            always_ff @(posedge aclk) begin
                if (advance) begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign quotient = quo_reg[Q_W-1];

endmodule

>>> src/nnis_coord_map.sv
// ----------------------------------------------------------------------------
// nnis_coord_map
// Map a target coordinate to a source store index; check loads against area.
// ----------------------------------------------------------------------------
module nnis_coord_map #(
    parameter int unsigned SRC_PIXELS = nnis_pkg::DEF_SRC_PIXELS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   in_valid,
    input  nnis_pkg::nnis_in_t     in_data,
    input  nnis_pkg::nnis_dims_t   dims,
    output logic                   acc_valid,
    output nnis_pkg::nnis_access_t acc
);
    import nnis_pkg::*;

    // Front stage
    logic              a_valid_reg;
    nnis_side_t        a_side_reg;
    nnis_side_t        a_side_next;
    logic [PROD_W-1:0] px_reg;
    logic [PROD_W-1:0] py_reg;
    logic [AREA_W-1:0] area;

    // Divider stages
    logic              d_valid_reg [Q_W];
    nnis_side_t        d_side_reg  [Q_W];
    logic [Q_W-1:0]    col;
    logic [Q_W-1:0]    row;

    // Index stage
    logic              acc_valid_reg;
    nnis_access_t      acc_reg;
    nnis_access_t      acc_next;
    logic [CALC_W-1:0] calc;

    // Decode the beat and form the products
    assign area = AREA_W'(dims.sw) * AREA_W'(dims.sh);

    always_comb begin
        a_side_next.fetch     = (in_data.opcode == OP_FETCH);
        a_side_next.load_ok   = (AREA_W'(in_data.src_index) < area) &&
                                (32'(in_data.src_index) < SRC_PIXELS);
        a_side_next.src_index = in_data.src_index;
        a_side_next.pixel     = in_data.pixel_in;
        a_side_next.oor       = (DDIM_W'(in_data.dst_x) >= dims.dw) ||
                                (DDIM_W'(in_data.dst_y) >= dims.dh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_side_reg <= a_side_next;
            px_reg     <= PROD_W'(in_data.dst_x) * PROD_W'(dims.sw);
            py_reg     <= PROD_W'(in_data.dst_y) * PROD_W'(dims.sh);
        end
    end

    // Column and row quotients
    nnis_divider u_div_x (
        .aclk     (aclk),
        .advance  (advance),
        .dividend (px_reg),
        .divisor  (dims.dw),
        .quotient (col)
    );

    nnis_divider u_div_y (
        .aclk     (aclk),
        .advance  (advance),
        .dividend (py_reg),
        .divisor  (dims.dh),
        .quotient (row)
    );

    // Carry valid and item state alongside the divider stages
    for (genvar k = 0; k < Q_W; k++) begin : g_side
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    d_valid_reg[k] <= 1'b0;
                end else if (advance) begin
                    d_valid_reg[k] <= a_valid_reg;
                end
            end
            always_ff @(posedge aclk) begin
                if (advance) begin
                    d_side_reg[k] <= a_side_reg;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    d_valid_reg[k] <= 1'b0;
                end else if (advance) begin
                    d_valid_reg[k] <= d_valid_reg[k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (advance) begin
                    d_side_reg[k] <= d_side_reg[k-1];
                end
            end
        end
    end

    // Form the store address: row-major index for a fetch, load index otherwise
    assign calc = CALC_W'(row) * CALC_W'(dims.sw) + CALC_W'(col);

    always_comb begin
        acc_next.fetch = d_side_reg[Q_W-1].fetch;
        acc_next.wdata = d_side_reg[Q_W-1].pixel;
        acc_next.oor   = d_side_reg[Q_W-1].oor;
        if (d_side_reg[Q_W-1].fetch) begin
            acc_next.wr_en = 1'b0;
            acc_next.index = calc;
            acc_next.zero  = d_side_reg[Q_W-1].oor || !(32'(calc) < SRC_PIXELS);
        end else begin
            acc_next.wr_en = d_side_reg[Q_W-1].load_ok;
            acc_next.index = CALC_W'(d_side_reg[Q_W-1].src_index);
            acc_next.zero  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
        end else if (advance) begin
            acc_valid_reg <= d_valid_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_valid = acc_valid_reg;
    assign acc       = acc_reg;

endmodule

>>> src/nnis_pixel_store.sv
// ----------------------------------------------------------------------------
// nnis_pixel_store
// Source image memory: write loads, read fetches, register the result beat.
// ----------------------------------------------------------------------------
module nnis_pixel_store #(
    parameter int unsigned SRC_PIXELS = nnis_pkg::DEF_SRC_PIXELS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   acc_valid,
    input  nnis_pkg::nnis_access_t acc,
    output logic                   out_valid,
    output nnis_pkg::nnis_out_t    out_data
);
    import nnis_pkg::*;

    localparam int ADDR_W = (SRC_PIXELS > 1) ? $clog2(SRC_PIXELS) : 1;

    logic [PIX_W-1:0]  mem [SRC_PIXELS];
    logic [ADDR_W-1:0] addr;

    // Read stage
    logic              r_valid_reg;
    logic              r_zero_reg;
    logic              r_oor_reg;
    logic [PIX_W-1:0]  rd_data_reg;

    // Output stage
    logic              out_valid_reg;
    nnis_out_t         out_reg;
    nnis_out_t         out_next;

    assign addr = ADDR_W'(acc.index);

    // Loads write and fetches read at the same stage, so order is kept
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (acc_valid && acc.wr_en) begin
                mem[addr] <= acc.wdata;
            end
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (advance) begin
            r_valid_reg <= acc_valid && acc.fetch;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            r_zero_reg <= acc.zero;
            r_oor_reg  <= acc.oor;
        end
    end

    // Drop the pixel for out-of-range fetches
    always_comb begin
        out_next.pixel_out    = r_zero_reg ? '0 : rd_data_reg;
        out_next.out_of_range = r_oor_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> src/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor RGBA scaler. Load beats (opcode 0) write one 32-bit pixel
// into the source store at a row-major index; loads outside the configured
// source area are dropped and give no result. Fetch beats (opcode 1) return
// the source pixel at column x*src_width/dst_width and row
// y*src_height/dst_height, or pixel 0 with out_of_range set when (x, y) lies
// outside the target size. One beat is accepted per clock. A fetch result
// passes one decode stage, six divider stages (one quotient bit each, both
// axes in parallel), one index stage, the memory read and the output
// register. The whole pipeline holds while a result waits on m_ready. The
// dimension registers (APB, 0x0..0xC) saturate into their legal range; the
// user must write them only while the pipeline is empty; this is unchecked.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_scaler_assert.svh"

module nearest_neighbor_image_scaler #(
    parameter int unsigned SRC_PIXELS = nnis_pkg::DEF_SRC_PIXELS
) (
    input  logic                aclk,
    input  logic                aresetn,

    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // Input beats
    input  logic                s_valid,
    output logic                s_ready,
    input  nnis_pkg::nnis_in_t  s_data,

    // Result beats
    output logic                m_valid,
    input  logic                m_ready,
    output nnis_pkg::nnis_out_t m_data
);
    import nnis_pkg::*;

    logic [SDIM_W-1:0] src_width_reg;
    logic [SDIM_W-1:0] src_height_reg;
    logic [DDIM_W-1:0] dst_width_reg;
    logic [DDIM_W-1:0] dst_height_reg;
    logic              cfg_write;
    reg_idx_t          cfg_sel;
    nnis_dims_t        dims;
    logic              advance;
    logic              acc_valid;
    nnis_access_t      acc;

    // Register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SDIM_W'(1);
            src_height_reg <= SDIM_W'(1);
            dst_width_reg  <= DDIM_W'(1);
            dst_height_reg <= DDIM_W'(1);
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[SDIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[SDIM_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[DDIM_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[DDIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            REG_DST_WIDTH:  prdata = 32'(dst_width_reg);
            REG_DST_HEIGHT: prdata = 32'(dst_height_reg);
        endcase
    end

    // Saturate the dimensions into their legal range
    always_comb begin
        dims.sw = clamp_sdim(src_width_reg);
        dims.sh = clamp_sdim(src_height_reg);
        dims.dw = clamp_ddim(dst_width_reg);
        dims.dh = clamp_ddim(dst_height_reg);
    end

    // Advance every stage unless a result waits at the output
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    nnis_coord_map #(
        .SRC_PIXELS (SRC_PIXELS)
    ) u_coord_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .dims      (dims),
        .acc_valid (acc_valid),
        .acc       (acc)
    );

    nnis_pixel_store #(
        .SRC_PIXELS (SRC_PIXELS)
    ) u_pixel_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .acc_valid (acc_valid),
        .acc       (acc),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // Out-of-range fetches carry a zero pixel
    `NNIS_ASSERT_IMPL(a_oor_zero, aclk, aresetn, m_valid && m_data.out_of_range, m_data.pixel_out == '0)
    // Input is held off only by a waiting result
    `NNIS_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)

endmodule
